@@ rtl/fmrc_pkg.sv @@
// ----------------------------------------------------------------------------
// First-match rule classifier package
// Word types for both channels, opcodes and condition mask bit positions.
// ----------------------------------------------------------------------------
package fmrc_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam int C_PROCESS  = 0;
  localparam int C_FUNCTION = 1;
  localparam int C_CALLER   = 2;
  localparam int C_LADDR    = 3;
  localparam int C_LPORT    = 4;
  localparam int C_RADDR    = 5;
  localparam int C_RPORT    = 6;

  localparam int COND_BITS  = 7;
  localparam int COUNT_BITS = 5;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         rule_index;
    logic [6:0]         cond_mask;
    logic [15:0]        process_id;
    logic [15:0]        function_id;
    logic [31:0]        caller_addr;
    logic [47:0]        local_endpoint;
    logic [47:0]        remote_endpoint;
    logic               local_present;
    logic               remote_present;
    logic signed [31:0] verdict_value;
    logic [31:0]        verdict_error;
  } in_word_t;

  typedef struct packed {
    logic               proceed;
    logic signed [31:0] forced_value;
    logic [31:0]        forced_error;
  } out_word_t;

endpackage

@@ rtl/fmrc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fmrc_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/fmrc_match.sv @@
// ----------------------------------------------------------------------------
// Rule match unit
// Checks one stored rule entry against the lookup word under its mask.
// ----------------------------------------------------------------------------
module fmrc_match #(
  parameter int unsigned IDW = 16
) (
  input  fmrc_pkg::in_word_t item,
  input  logic [6:0]         e_cond,
  input  logic [IDW-1:0]     e_proc,
  input  logic [IDW-1:0]     e_func,
  input  logic [31:0]        e_caller,
  input  logic [47:0]        e_local,
  input  logic [47:0]        e_remote,
  output logic               hit
);

  logic proc_ok;
  logic func_ok;
  logic caller_ok;
  logic laddr_ok;
  logic lport_ok;
  logic raddr_ok;
  logic rport_ok;

  assign proc_ok   = !e_cond[fmrc_pkg::C_PROCESS] || (item.process_id[IDW-1:0] == e_proc);
  assign func_ok   = !e_cond[fmrc_pkg::C_FUNCTION] || (item.function_id[IDW-1:0] == e_func);
  assign caller_ok = !e_cond[fmrc_pkg::C_CALLER] || (item.caller_addr == e_caller);
  assign laddr_ok  = !e_cond[fmrc_pkg::C_LADDR] ||
                     (item.local_present && (item.local_endpoint[47:16] == e_local[47:16]));
  assign lport_ok  = !e_cond[fmrc_pkg::C_LPORT] ||
                     (item.local_present && (item.local_endpoint[15:0] == e_local[15:0]));
  assign raddr_ok  = !e_cond[fmrc_pkg::C_RADDR] ||
                     (item.remote_present && (item.remote_endpoint[47:16] == e_remote[47:16]));
  assign rport_ok  = !e_cond[fmrc_pkg::C_RPORT] ||
                     (item.remote_present && (item.remote_endpoint[15:0] == e_remote[15:0]));

  assign hit = proc_ok && func_ok && caller_ok && laddr_ok && lport_ok && raddr_ok && rport_ok;

endmodule

@@ rtl/first_match_rule_classifier_core.sv @@
// ----------------------------------------------------------------------------
// First-match rule classifier core
// Rule writes can follow back to back. A lookup reads one rule per cycle from
// rule zero up and stops at the first hit; that rule's verdict, or a proceed word
// on a miss or an empty table, is registered once no result is held stalled at
// the output. The next word is taken once the result is registered.
// Reset is synchronous and clears control state and the rule count only.
// ----------------------------------------------------------------------------
module first_match_rule_classifier_core #(
  parameter int unsigned RULES   = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fmrc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output fmrc_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  localparam int unsigned IDW   = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int unsigned AW    = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned EW    = fmrc_pkg::COND_BITS + 2 * IDW + 32 + 48 + 48 + 32 + 32;
  localparam int unsigned O_ERR = 0;
  localparam int unsigned O_VAL = O_ERR + 32;
  localparam int unsigned O_REM = O_VAL + 32;
  localparam int unsigned O_LOC = O_REM + 48;
  localparam int unsigned O_CAL = O_LOC + 48;
  localparam int unsigned O_FUN = O_CAL + 32;
  localparam int unsigned O_PRC = O_FUN + IDW;
  localparam int unsigned O_CND = O_PRC + IDW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  fmrc_pkg::in_word_t  item_r, item_nxt;
  logic [4:0]          count_r, count_nxt;
  logic [4:0]          n_r, n_nxt;
  logic [4:0]          issue_r, issue_nxt;
  logic                pending_r, pending_nxt;
  logic                out_valid_r, out_valid_nxt;
  fmrc_pkg::out_word_t out_word_r, out_word_nxt;

  logic                in_accept;
  logic [4:0]          n_w;
  logic                wr_en;
  logic [8:0]          widx;
  logic [8:0]          ridx;
  logic                rd_en;
  logic [EW-1:0]       wr_entry;
  logic [EW-1:0]       rd_entry;
  logic                hit;
  logic                done;
  logic                finish;
  fmrc_pkg::out_word_t res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign n_w       = (32'(count_r) > RULES) ? 5'(RULES) : count_r;

  assign wr_en = in_accept && (in_word.opcode == fmrc_pkg::OP_WRITE) &&
                 (32'(in_word.rule_index) < RULES);
  assign widx  = {5'b0, in_word.rule_index};
  assign ridx  = {4'b0, issue_r};
  assign wr_entry = {in_word.cond_mask, in_word.process_id[IDW-1:0],
                     in_word.function_id[IDW-1:0], in_word.caller_addr,
                     in_word.local_endpoint, in_word.remote_endpoint,
                     in_word.verdict_value, in_word.verdict_error};

  fmrc_ram #(
    .WIDTH (EW),
    .DEPTH (RULES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (widx[AW-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (ridx[AW-1:0]),
    .rdata (rd_entry)
  );

  fmrc_match #(
    .IDW (IDW)
  ) u_match (
    .item     (item_r),
    .e_cond   (rd_entry[O_CND +: fmrc_pkg::COND_BITS]),
    .e_proc   (rd_entry[O_PRC +: IDW]),
    .e_func   (rd_entry[O_FUN +: IDW]),
    .e_caller (rd_entry[O_CAL +: 32]),
    .e_local  (rd_entry[O_LOC +: 48]),
    .e_remote (rd_entry[O_REM +: 48]),
    .hit      (hit)
  );

  assign done   = (pending_r && hit) || (!pending_r && (issue_r == n_r));
  assign finish = (state_r == ST_SCAN) && done && (!out_valid_r || !out_stall);
  assign rd_en  = (state_r == ST_SCAN) && !done && (issue_r < n_r);

  always_comb begin
    res.proceed      = !(pending_r && hit);
    res.forced_value = (pending_r && hit) ? rd_entry[O_VAL +: 32] : 32'sd0;
    res.forced_error = (pending_r && hit) ? rd_entry[O_ERR +: 32] : 32'd0;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = cfg_we ? cfg_wdata : count_r;
    n_nxt         = n_r;
    issue_nxt     = issue_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_word.opcode == fmrc_pkg::OP_LOOKUP)) begin
          item_nxt    = in_word;
          n_nxt       = n_w;
          issue_nxt   = 5'd0;
          pending_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res;
          pending_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (!done) begin
          pending_nxt = rd_en;
          if (rd_en) begin
            issue_nxt = issue_r + 5'd1;
          end
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        pending_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= 5'd0;
      n_r         <= 5'd0;
      issue_r     <= 5'd0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      issue_r     <= issue_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/fmrc_checker.sv @@
// ----------------------------------------------------------------------------
// First-match rule classifier checker
// Port-level properties of the classifier core, bound to the core module.
// ----------------------------------------------------------------------------
module fmrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input fmrc_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input fmrc_pkg::out_word_t out_word
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // A word that lets the call proceed never forces a value or an error.
  a_proceed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.proceed |-> (out_word.forced_value == 32'sd0) &&
    (out_word.forced_error == 32'd0))
    else $error("proceed word with nonzero forced fields");

  // An accepted lookup occupies the block in the next cycle.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.opcode == fmrc_pkg::OP_LOOKUP) |=> in_stall)
    else $error("lookup accepted without the block turning busy");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind first_match_rule_classifier_core fmrc_checker u_fmrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-match rule classifier testbench
// Drives rule writes and lookups through the valid/stall channels with random
// gaps and back-pressure. A scoreboard keeps its own copy of the rule table and
// of the rule count, works out the verdict of every accepted lookup and
// compares each result word against the oldest pending verdict.
// ----------------------------------------------------------------------------
class fmrc_scoreboard;

  localparam int TABLE_DEPTH = 16;

  logic [6:0]  rule_cond   [TABLE_DEPTH];
  logic [15:0] rule_proc   [TABLE_DEPTH];
  logic [15:0] rule_func   [TABLE_DEPTH];
  logic [31:0] rule_caller [TABLE_DEPTH];
  logic [47:0] rule_lend   [TABLE_DEPTH];
  logic [47:0] rule_rend   [TABLE_DEPTH];
  logic [31:0] rule_value  [TABLE_DEPTH];
  logic [31:0] rule_error  [TABLE_DEPTH];

  int unsigned            rule_count;
  fmrc_pkg::out_word_t    verdict_q [$];
  int unsigned            failures;

  function new();
    rule_count = 0;
    failures   = 0;
  endfunction

  function void set_rule_count(logic [4:0] count);
    rule_count = 32'(count);
  endfunction

  function int unsigned rules_in_use();
    return (rule_count > TABLE_DEPTH) ? TABLE_DEPTH : rule_count;
  endfunction

  function bit rule_hits(int unsigned i, fmrc_pkg::in_word_t w);
    logic [6:0] c;
    c = rule_cond[i];
    if (c[fmrc_pkg::C_PROCESS] && w.process_id != rule_proc[i]) return 1'b0;
    if (c[fmrc_pkg::C_FUNCTION] && w.function_id != rule_func[i]) return 1'b0;
    if (c[fmrc_pkg::C_CALLER] && w.caller_addr != rule_caller[i]) return 1'b0;
    if (c[fmrc_pkg::C_LADDR] &&
        (!w.local_present || w.local_endpoint[47:16] != rule_lend[i][47:16]))
      return 1'b0;
    if (c[fmrc_pkg::C_LPORT] &&
        (!w.local_present || w.local_endpoint[15:0] != rule_lend[i][15:0]))
      return 1'b0;
    if (c[fmrc_pkg::C_RADDR] &&
        (!w.remote_present || w.remote_endpoint[47:16] != rule_rend[i][47:16]))
      return 1'b0;
    if (c[fmrc_pkg::C_RPORT] &&
        (!w.remote_present || w.remote_endpoint[15:0] != rule_rend[i][15:0]))
      return 1'b0;
    return 1'b1;
  endfunction

  function void note_word(fmrc_pkg::in_word_t w);
    fmrc_pkg::out_word_t verdict;
    int unsigned         i;
    if (w.opcode == fmrc_pkg::OP_WRITE) begin
      i              = 32'(w.rule_index);
      rule_cond[i]   = w.cond_mask;
      rule_proc[i]   = w.process_id;
      rule_func[i]   = w.function_id;
      rule_caller[i] = w.caller_addr;
      rule_lend[i]   = w.local_endpoint;
      rule_rend[i]   = w.remote_endpoint;
      rule_value[i]  = w.verdict_value;
      rule_error[i]  = w.verdict_error;
      return;
    end
    verdict.proceed      = 1'b1;
    verdict.forced_value = '0;
    verdict.forced_error = '0;
    for (i = 0; i < rules_in_use(); i++) begin
      if (rule_hits(i, w)) begin
        verdict.proceed      = 1'b0;
        verdict.forced_value = rule_value[i];
        verdict.forced_error = rule_error[i];
        break;
      end
    end
    verdict_q.push_back(verdict);
  endfunction

  function void check_word(fmrc_pkg::out_word_t got);
    fmrc_pkg::out_word_t exp_word;
    if (verdict_q.size() == 0) begin
      $display("%0t: unexpected result word, proceed %0d value %0d error %h",
               $time, got.proceed, got.forced_value, got.forced_error);
      failures++;
      return;
    end
    exp_word = verdict_q.pop_front();
    if (got.proceed !== exp_word.proceed) begin
      $display("%0t: proceed mismatch, expected %0d, got %0d",
               $time, exp_word.proceed, got.proceed);
      failures++;
    end
    if (got.forced_value !== exp_word.forced_value) begin
      $display("%0t: forced_value mismatch, expected %0d, got %0d",
               $time, exp_word.forced_value, got.forced_value);
      failures++;
    end
    if (got.forced_error !== exp_word.forced_error) begin
      $display("%0t: forced_error mismatch, expected %h, got %h",
               $time, exp_word.forced_error, got.forced_error);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return verdict_q.size();
  endfunction

endclass

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 160;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fmrc_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fmrc_pkg::out_word_t out_word;
  logic                cfg_we    = 1'b0;
  logic [4:0]          cfg_wdata = '0;

  bit          in_burst;
  bit          out_burst;
  int unsigned quiet_cycles;

  fmrc_scoreboard sb = new();

  first_match_rule_classifier_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_word(out_word);
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 3));
      1:       return ~32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    return 16'(pick32());
  endfunction

  function automatic fmrc_pkg::in_word_t write_word(logic [3:0] idx, logic [6:0] mask,
      logic [15:0] proc, logic [15:0] func, logic [31:0] caller, logic [47:0] lend,
      logic [47:0] rend, logic [31:0] value, logic [31:0] error);
    fmrc_pkg::in_word_t w;
    w.opcode          = fmrc_pkg::OP_WRITE;
    w.rule_index      = idx;
    w.cond_mask       = mask;
    w.process_id      = proc;
    w.function_id     = func;
    w.caller_addr     = caller;
    w.local_endpoint  = lend;
    w.remote_endpoint = rend;
    w.local_present   = 1'($urandom);
    w.remote_present  = 1'($urandom);
    w.verdict_value   = value;
    w.verdict_error   = error;
    return w;
  endfunction

  function automatic fmrc_pkg::in_word_t lookup_word(logic [15:0] proc, logic [15:0] func,
      logic [31:0] caller, logic [47:0] lend, logic [47:0] rend, logic lp, logic rp);
    fmrc_pkg::in_word_t w;
    w.opcode          = fmrc_pkg::OP_LOOKUP;
    w.rule_index      = 4'($urandom);
    w.cond_mask       = 7'($urandom);
    w.process_id      = proc;
    w.function_id     = func;
    w.caller_addr     = caller;
    w.local_endpoint  = lend;
    w.remote_endpoint = rend;
    w.local_present   = lp;
    w.remote_present  = rp;
    w.verdict_value   = $urandom;
    w.verdict_error   = $urandom;
    return w;
  endfunction

  function automatic fmrc_pkg::in_word_t random_rule(logic [3:0] idx);
    logic [6:0] mask;
    mask = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom & $urandom);
    return write_word(idx, mask, pick16(), pick16(), pick32(),
                      {pick32(), pick16()}, {pick32(), pick16()}, pick32(), pick32());
  endfunction

  function automatic fmrc_pkg::in_word_t random_lookup();
    fmrc_pkg::in_word_t w;
    int unsigned        n;
    int unsigned        j;
    n = sb.rules_in_use();
    if (n != 0 && $urandom_range(0, 9) < 7) begin
      j = $urandom_range(0, n - 1);
      w = lookup_word(sb.rule_proc[j], sb.rule_func[j], sb.rule_caller[j],
                      sb.rule_lend[j], sb.rule_rend[j],
                      $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       w.process_id[$urandom_range(0, 15)] ^= 1'b1;
          1:       w.function_id[$urandom_range(0, 15)] ^= 1'b1;
          2:       w.caller_addr[$urandom_range(0, 31)] ^= 1'b1;
          3:       w.local_endpoint[$urandom_range(0, 47)] ^= 1'b1;
          default: w.remote_endpoint[$urandom_range(0, 47)] ^= 1'b1;
        endcase
      end
    end else begin
      w = lookup_word(pick16(), pick16(), pick32(), {pick32(), pick16()},
                      {pick32(), pick16()}, 1'($urandom), 1'($urandom));
    end
    return w;
  endfunction

  task automatic send_word(input fmrc_pkg::in_word_t w);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rule_count(input logic [4:0] count);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_rule_count(count);
  endtask

  initial begin
    logic [4:0] phase_counts [10];
    int unsigned p;
    int unsigned k;
    phase_counts = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd0, 5'd0, 5'd8, 5'd0, 5'd16};
    phase_counts[5] = 5'($urandom);
    phase_counts[6] = 5'($urandom);
    phase_counts[8] = 5'($urandom);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(lookup_word('1, '1, '1, '1, '1, 1'b1, 1'b1));
    send_word(lookup_word('0, '0, '0, '0, '0, 1'b0, 1'b0));
    send_word(write_word(4'd0, 7'h7f, 16'hffff, 16'h0000, 32'hffffffff,
                         {32'hffffffff, 16'h0000}, {32'h00000000, 16'hffff},
                         32'h7fffffff, 32'h00000001));
    send_word(write_word(4'd1, 7'h18, 16'h0000, 16'h0000, 32'h0,
                         {32'hc0a80001, 16'h0050}, 48'h0, 32'hffffffff, 32'h0000000d));
    send_word(write_word(4'd2, 7'h60, 16'h0000, 16'h0000, 32'h0,
                         48'h0, {32'h08080808, 16'h0035}, 32'h0, 32'hffffffff));
    send_word(write_word(4'd3, 7'h00, 16'h5555, 16'haaaa, 32'h12345678,
                         '1, '1, 32'h80000000, 32'h0));
    send_word(write_word(4'd15, 7'h03, 16'h1234, 16'habcd, 32'h0,
                         48'h0, 48'h0, 32'd5, 32'd2));
    set_rule_count(5'd4);
    send_word(lookup_word(16'hffff, 16'h0000, 32'hffffffff, {32'hffffffff, 16'h0000},
                          {32'h00000000, 16'hffff}, 1'b1, 1'b1));
    send_word(lookup_word(16'hffff, 16'h0000, 32'hffffffff, {32'hffffffff, 16'h0000},
                          {32'h00000000, 16'hffff}, 1'b0, 1'b1));
    send_word(lookup_word(16'h0, 16'h0, 32'h0, {32'hc0a80001, 16'h0050}, 48'h0,
                          1'b1, 1'b0));
    send_word(lookup_word(16'h0, 16'h0, 32'h0, {32'hc0a80001, 16'h0051},
                          {32'h08080808, 16'h0035}, 1'b1, 1'b1));
    send_word(lookup_word(16'h0, 16'h0, 32'h0, {32'hc0a80001, 16'h0051},
                          {32'h08080808, 16'h0035}, 1'b1, 1'b0));
    set_rule_count(5'd0);
    send_word(lookup_word(16'hffff, 16'h0000, 32'hffffffff, {32'hffffffff, 16'h0000},
                          {32'h00000000, 16'hffff}, 1'b1, 1'b1));
    set_rule_count(5'd3);
    send_word(lookup_word(16'h0, 16'hffff, 32'h0, 48'h0, 48'h0, 1'b1, 1'b1));
    send_word(lookup_word(16'h0, 16'hffff, 32'h0, 48'h0, {32'h08080808, 16'h0035},
                          1'b1, 1'b1));

    for (k = 4; k < 15; k++) send_word(random_rule(4'(k)));

    for (p = 0; p < 10; p++) begin
      set_rule_count(phase_counts[p]);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 4) == 0) send_word(random_rule(4'($urandom)));
        else send_word(random_lookup());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fmrc_pkg.sv
rtl/fmrc_ram.sv
rtl/fmrc_match.sv
rtl/first_match_rule_classifier_core.sv
rtl/fmrc_checker.sv
dv/tb_top.sv
